// ===== hdl/dsf_pkg.sv =====
// Shared types, constants and fixed-point helpers for the diagonal
// state-space filter. No dependencies.
`timescale 1ns / 1ps

package dsf_pkg;

   localparam int CHANNELS_DEF   = 16;
   localparam int STATE_SIZE_DEF = 64;
   localparam int FRAC           = 20;

   localparam logic [22:0] STEP_RESET = 23'd52429;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam logic [2:0] SEL_POLE_RE    = 3'd0;
   localparam logic [2:0] SEL_POLE_IM    = 3'd1;
   localparam logic [2:0] SEL_INPUT_GAIN = 3'd2;
   localparam logic [2:0] SEL_READ_RE    = 3'd3;
   localparam logic [2:0] SEL_READ_IM    = 3'd4;
   localparam logic [2:0] SEL_DIRECT     = 3'd5;

   localparam logic signed [63:0] HALF_LSB = 64'sd524288;
   localparam logic signed [63:0] S32_MAX  = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN  = -64'sd2147483648;
   localparam logic signed [63:0] S24_MAX  = 64'sd8388607;
   localparam logic signed [63:0] S24_MIN  = -64'sd8388608;

   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         channel;
      logic [5:0]         entry_index;
      logic [2:0]         coef_select;
      logic signed [23:0] coef_value;
      logic signed [23:0] sample;
   } req_type;

   typedef struct packed {
      logic [3:0]         out_channel;
      logic signed [23:0] out_sample;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic issue;
      logic first;
      logic last;
   } ctl_type;

   typedef struct packed {
      logic               en;
      logic [2:0]         sel;
      logic signed [23:0] value;
   } coef_wr_type;

   // Round half up to the Q.20 grid.
   function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
      return (p + HALF_LSB) >>> FRAC;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > S32_MAX) begin
         r = S32_MAX;
      end else if (v < S32_MIN) begin
         r = S32_MIN;
      end
      return 32'(r);
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > S24_MAX) begin
         r = S24_MAX;
      end else if (v < S24_MIN) begin
         r = S24_MIN;
      end
      return 24'(r);
   endfunction

   function automatic logic ovf24(input logic signed [63:0] v);
      return (v > S24_MAX) || (v < S24_MIN);
   endfunction

endpackage

// ===== hdl/dsf_coef_mem.sv =====
// Coefficient memories: five per-entry tables and the per-channel direct gain.
// Depends on dsf_pkg.
`timescale 1ns / 1ps

module dsf_coef_mem #(
   parameter int CHANNELS   = dsf_pkg::CHANNELS_DEF,
   parameter int STATE_SIZE = dsf_pkg::STATE_SIZE_DEF,
   parameter int AW         = 10,
   parameter int CW         = 4
) (
   input  logic                 clock,
   input  dsf_pkg::coef_wr_type wr,
   input  logic [AW-1:0]        wr_addr,
   input  logic [CW-1:0]        wr_chan,
   input  logic [AW-1:0]        rd_addr,
   input  logic [CW-1:0]        rd_chan,
   output logic signed [23:0]   pole_re,
   output logic signed [23:0]   pole_im,
   output logic signed [23:0]   in_gain,
   output logic signed [23:0]   read_re,
   output logic signed [23:0]   read_im,
   output logic signed [23:0]   direct
);

   localparam int CELLS = CHANNELS * STATE_SIZE;

   logic signed [23:0] mem_pr [CELLS];
   logic signed [23:0] mem_pi [CELLS];
   logic signed [23:0] mem_b  [CELLS];
   logic signed [23:0] mem_cr [CELLS];
   logic signed [23:0] mem_ci [CELLS];
   logic signed [23:0] mem_d  [CHANNELS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         case (wr.sel)
            dsf_pkg::SEL_POLE_RE:    mem_pr[wr_addr] <= wr.value;
            dsf_pkg::SEL_POLE_IM:    mem_pi[wr_addr] <= wr.value;
            dsf_pkg::SEL_INPUT_GAIN: mem_b[wr_addr]  <= wr.value;
            dsf_pkg::SEL_READ_RE:    mem_cr[wr_addr] <= wr.value;
            dsf_pkg::SEL_READ_IM:    mem_ci[wr_addr] <= wr.value;
            dsf_pkg::SEL_DIRECT:     mem_d[wr_chan]  <= wr.value;
            default: ;
         endcase
      end
      pole_re <= mem_pr[rd_addr];
      pole_im <= mem_pi[rd_addr];
      in_gain <= mem_b[rd_addr];
      read_re <= mem_cr[rd_addr];
      read_im <= mem_ci[rd_addr];
      direct  <= mem_d[rd_chan];
   end

endmodule

// ===== hdl/dsf_state_mem.sv =====
// Recurrence state memory, real and imaginary parts, one write and one read port.
// Depends on dsf_pkg for parameter defaults.
`timescale 1ns / 1ps

module dsf_state_mem #(
   parameter int CHANNELS   = dsf_pkg::CHANNELS_DEF,
   parameter int STATE_SIZE = dsf_pkg::STATE_SIZE_DEF,
   parameter int AW         = 10
) (
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      wr_addr,
   input  logic signed [31:0] wr_re,
   input  logic signed [31:0] wr_im,
   input  logic [AW-1:0]      rd_addr,
   output logic signed [31:0] rd_re,
   output logic signed [31:0] rd_im
);

   localparam int CELLS = CHANNELS * STATE_SIZE;

   logic signed [31:0] mem_re [CELLS];
   logic signed [31:0] mem_im [CELLS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_re[wr_addr] <= wr_re;
         mem_im[wr_addr] <= wr_im;
      end
      rd_re <= mem_re[rd_addr];
      rd_im <= mem_im[rd_addr];
   end

endmodule

// ===== hdl/dsf_datapath.sv =====
// Pipelined entry update, state write-back and readout accumulation.
// Depends on dsf_pkg.
`timescale 1ns / 1ps

module dsf_datapath #(
   parameter int STATE_SIZE = dsf_pkg::STATE_SIZE_DEF,
   parameter int AW         = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  dsf_pkg::ctl_type   ctl,
   input  logic [AW-1:0]      rd_addr,
   input  logic [22:0]        step_size,
   input  logic signed [23:0] u,
   input  logic signed [23:0] pole_re,
   input  logic signed [23:0] pole_im,
   input  logic signed [23:0] in_gain,
   input  logic signed [23:0] read_re,
   input  logic signed [23:0] read_im,
   input  logic signed [23:0] direct,
   input  logic signed [31:0] h_re,
   input  logic signed [31:0] h_im,
   output logic               wb_we,
   output logic [AW-1:0]      wb_addr,
   output logic signed [31:0] wb_re,
   output logic signed [31:0] wb_im,
   output logic               done,
   output logic signed [23:0] y,
   output logic               y_sat
);

   localparam int EW    = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;
   localparam int ACC_W = 38 + EW;

   logic [7:1] v_ff;
   logic [7:1] first_ff;
   logic [7:1] last_ff;
   logic [AW-1:0] addr_ff [1:5];

   logic signed [23:0] cr_ff [2:5];
   logic signed [23:0] ci_ff [2:5];

   logic signed [47:0] gp_ff;
   logic signed [55:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [47:0] dp_ff;
   logic signed [36:0] re3_ff, im3_ff, re4_ff, im4_ff;
   logic signed [27:0] gain_ff;
   logic signed [51:0] drv_ff;
   logic signed [31:0] nr_ff, ni_ff;
   logic signed [55:0] p_cr_ff, p_ci_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [36:0] term;
   logic signed [63:0] y_full;
   logic signed [23:0] step_s;

   assign step_s = $signed({1'b0, step_size});
   assign term   = 37'(dsf_pkg::rnd(64'(p_cr_ff) - 64'(p_ci_ff)));
   assign y_full = (64'(acc_ff) <<< 1) + dsf_pkg::rnd(64'(dp_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         done    <= 1'b0;
      end else begin
         v_ff    <= {v_ff[6:1], ctl.issue};
         done    <= v_ff[7] && last_ff[7];
      end
   end

   always_ff @(posedge clock) begin
      first_ff   <= {first_ff[6:1], ctl.first};
      last_ff    <= {last_ff[6:1], ctl.last};
      addr_ff[1] <= rd_addr;
      for (int i = 2; i <= 5; i++) begin
         addr_ff[i] <= addr_ff[i-1];
      end
      cr_ff[2] <= read_re;
      ci_ff[2] <= read_im;
      for (int i = 3; i <= 5; i++) begin
         cr_ff[i] <= cr_ff[i-1];
         ci_ff[i] <= ci_ff[i-1];
      end

      gp_ff   <= step_s * in_gain;
      p_rr_ff <= pole_re * h_re;
      p_ii_ff <= pole_im * h_im;
      p_ri_ff <= pole_re * h_im;
      p_ir_ff <= pole_im * h_re;
      dp_ff   <= direct * u;

      re3_ff  <= 37'(dsf_pkg::rnd(64'(p_rr_ff) - 64'(p_ii_ff)));
      im3_ff  <= 37'(dsf_pkg::rnd(64'(p_ri_ff) + 64'(p_ir_ff)));
      gain_ff <= 28'(dsf_pkg::rnd(64'(gp_ff)));

      drv_ff  <= gain_ff * u;
      re4_ff  <= re3_ff;
      im4_ff  <= im3_ff;

      nr_ff   <= dsf_pkg::sat32(64'(re4_ff) + dsf_pkg::rnd(64'(drv_ff)));
      ni_ff   <= dsf_pkg::sat32(64'(im4_ff));

      p_cr_ff <= cr_ff[5] * nr_ff;
      p_ci_ff <= ci_ff[5] * ni_ff;

      if (v_ff[6]) begin
         acc_ff <= (first_ff[6] ? '0 : acc_ff) + ACC_W'(term);
      end

      if (v_ff[7] && last_ff[7]) begin
         y     <= dsf_pkg::sat24(y_full);
         y_sat <= dsf_pkg::ovf24(y_full);
      end
   end

   assign wb_we   = v_ff[5];
   assign wb_addr = addr_ff[5];
   assign wb_re   = nr_ff;
   assign wb_im   = ni_ff;

endmodule

// ===== hdl/diagonal_state_space_filter.sv =====
// Top level of the diagonal state-space filter: control sequencer, step
// register, result register. Depends on dsf_pkg, dsf_coef_mem, dsf_state_mem
// and dsf_datapath.
//
//   Port group  Direction  Handshake         Carries
//   req_*       in         valid / stall     one request (dsf_pkg::req_type)
//   rsp_*       out        valid / stall     one result (dsf_pkg::rsp_type)
//   csr_*       in         write enable      step_size, 23 bits
//
// For a sample request, one state entry is read per cycle from the state memory, then the
// update and readout pipeline drains and the result is raised once no earlier result is
// held by rsp_stall. The next request can be taken in the same cycle as the result is raised.
// A coefficient write or an ignored request leaves the sequencer idle.
// A clear request, and every reset, runs a clearing pass over all CHANNELS * STATE_SIZE
// cells of the state memory; requests are stalled meanwhile.
// A new request is taken while an earlier result waits on rsp_stall.
`timescale 1ns / 1ps

module diagonal_state_space_filter #(
   parameter int CHANNELS   = dsf_pkg::CHANNELS_DEF,
   parameter int STATE_SIZE = dsf_pkg::STATE_SIZE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dsf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dsf_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [22:0]      csr_wr_data
);

   localparam int CELLS = CHANNELS * STATE_SIZE;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int EW    = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;
   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [EW-1:0] N_LAST   = EW'(STATE_SIZE - 1);
   localparam logic [AW-1:0] CLR_LAST = AW'(CELLS - 1);

   typedef enum logic [2:0] {IDLE, CLEAR, RUN, DRAIN, DELIVER} state_type;

   state_type          state_ff;
   logic [EW-1:0]      n_ff;
   logic [AW-1:0]      clr_ff;
   logic [AW-1:0]      base_ff;
   logic [3:0]         ch_ff;
   logic [CW-1:0]      chi_ff;
   logic signed [23:0] u_ff;
   logic [22:0]        step_ff;
   logic               rsp_valid_ff;
   dsf_pkg::rsp_type   rsp_data_ff;

   logic                 accept;
   logic                 ch_ok;
   dsf_pkg::coef_wr_type coef_wr;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   dsf_pkg::ctl_type     ctl;

   logic signed [23:0] pole_re, pole_im, in_gain, read_re, read_im, direct;
   logic signed [31:0] h_re, h_im;
   logic               dp_wb_we;
   logic [AW-1:0]      dp_wb_addr;
   logic signed [31:0] dp_wb_re, dp_wb_im;
   logic               dp_done;
   logic signed [23:0] dp_y;
   logic               dp_sat;
   logic               st_we;
   logic [AW-1:0]      st_addr;
   logic signed [31:0] st_re, st_im;

   assign req_stall = (state_ff != IDLE);
   assign accept    = req_valid && !req_stall;
   assign ch_ok     = int'(req_data.channel) < CHANNELS;
   assign wr_addr   = AW'(int'(req_data.channel) * STATE_SIZE + int'(req_data.entry_index));
   assign rd_addr   = base_ff + AW'(n_ff);

   assign coef_wr.en = accept && (req_data.kind == dsf_pkg::KIND_WRITE) && ch_ok &&
                       ((req_data.coef_select == dsf_pkg::SEL_DIRECT) ||
                        (int'(req_data.entry_index) < STATE_SIZE));
   assign coef_wr.sel   = req_data.coef_select;
   assign coef_wr.value = req_data.coef_value;

   assign ctl.issue = (state_ff == RUN);
   assign ctl.first = (n_ff == '0);
   assign ctl.last  = (n_ff == N_LAST);

   assign st_we   = (state_ff == CLEAR) || dp_wb_we;
   assign st_addr = (state_ff == CLEAR) ? clr_ff : dp_wb_addr;
   assign st_re   = (state_ff == CLEAR) ? '0 : dp_wb_re;
   assign st_im   = (state_ff == CLEAR) ? '0 : dp_wb_im;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= dsf_pkg::STEP_RESET;
      end else if (csr_wr_en) begin
         step_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         clr_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != DELIVER) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  if (req_data.kind == dsf_pkg::KIND_CLEAR) begin
                     clr_ff   <= '0;
                     state_ff <= CLEAR;
                  end else if (req_data.kind == dsf_pkg::KIND_SAMPLE && ch_ok) begin
                     ch_ff    <= req_data.channel;
                     chi_ff   <= CW'(req_data.channel);
                     base_ff  <= AW'(int'(req_data.channel) * STATE_SIZE);
                     u_ff     <= req_data.sample;
                     n_ff     <= '0;
                     state_ff <= RUN;
                  end
               end
            end
            CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLR_LAST) begin
                  state_ff <= IDLE;
               end
            end
            RUN: begin
               n_ff <= n_ff + 1'b1;
               if (n_ff == N_LAST) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               if (dp_done) begin
                  state_ff <= DELIVER;
               end
            end
            DELIVER: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.out_channel <= ch_ff;
                  rsp_data_ff.out_sample  <= dp_y;
                  rsp_data_ff.saturated   <= dp_sat;
                  state_ff                <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   dsf_coef_mem #(
      .CHANNELS(CHANNELS), .STATE_SIZE(STATE_SIZE), .AW(AW), .CW(CW)
   ) u_coef (
      .clock(clock), .wr(coef_wr), .wr_addr(wr_addr),
      .wr_chan(CW'(req_data.channel)), .rd_addr(rd_addr), .rd_chan(chi_ff),
      .pole_re(pole_re), .pole_im(pole_im), .in_gain(in_gain),
      .read_re(read_re), .read_im(read_im), .direct(direct)
   );

   dsf_state_mem #(
      .CHANNELS(CHANNELS), .STATE_SIZE(STATE_SIZE), .AW(AW)
   ) u_state (
      .clock(clock), .we(st_we), .wr_addr(st_addr), .wr_re(st_re), .wr_im(st_im),
      .rd_addr(rd_addr), .rd_re(h_re), .rd_im(h_im)
   );

   dsf_datapath #(
      .STATE_SIZE(STATE_SIZE), .AW(AW)
   ) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .rd_addr(rd_addr),
      .step_size(step_ff), .u(u_ff),
      .pole_re(pole_re), .pole_im(pole_im), .in_gain(in_gain),
      .read_re(read_re), .read_im(read_im), .direct(direct),
      .h_re(h_re), .h_im(h_im),
      .wb_we(dp_wb_we), .wb_addr(dp_wb_addr), .wb_re(dp_wb_re), .wb_im(dp_wb_im),
      .done(dp_done), .y(dp_y), .y_sat(dp_sat)
   );

   // The clearing pass and the write-back never compete for the state port.
   a_clear_no_wb: assert property (@(posedge clock) disable iff (reset)
      state_ff == CLEAR |-> !dp_wb_we)
      else $error("write-back during clearing pass");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      dp_done |-> state_ff == DRAIN)
      else $error("datapath finished outside drain");

   a_rsp_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == DELIVER)
      else $error("result raised without a finished sample");

   a_no_coef_write_busy: assert property (@(posedge clock) disable iff (reset)
      coef_wr.en |-> state_ff == IDLE)
      else $error("coefficient write while busy");

endmodule

// ===== tb/sv/tb_diagonal_state_space_filter.sv =====
// Self-checking testbench for the diagonal state-space filter: loads the coefficient
// tables of a few channels, runs a directed table and random phases over several step sizes.
// Depends on dsf_pkg and the diagonal_state_space_filter top level.
`timescale 1ns / 1ps

module tb_diagonal_state_space_filter;

   localparam int NCH = dsf_pkg::CHANNELS_DEF;
   localparam int NST = dsf_pkg::STATE_SIZE_DEF;
   localparam int NLOAD = 3;
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [2:0] SEL_SPARE_A = 3'd6;
   localparam logic [2:0] SEL_SPARE_B = 3'd7;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 1200;

   typedef struct {
      dsf_pkg::req_type req;
      bit               known;
      dsf_pkg::rsp_type rsp;
   } vector_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   dsf_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   dsf_pkg::rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [22:0] csr_wr_data = '0;

   int pole_re_tab[NCH][NST];
   int pole_im_tab[NCH][NST];
   int in_gain_tab[NCH][NST];
   int read_re_tab[NCH][NST];
   int read_im_tab[NCH][NST];
   int direct_tab[NCH];
   int hist_re[NCH][NST];
   int hist_im[NCH][NST];
   logic [22:0] step_now = dsf_pkg::STEP_RESET;

   dsf_pkg::rsp_type pending_outputs[$];
   int errors = 0;
   int mismatches = 0;
   int requests_sent = 0;
   int outputs_seen = 0;
   int clears_sent = 0;
   int idle_cycles = 0;
   int hold_cycles = 0;
   bit hold_done = 1'b0;
   bit quiet = 1'b0;
   bit done = 1'b0;

   diagonal_state_space_filter u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint round_q20(input longint p);
      return (p + 64'sd524288) >>> dsf_pkg::FRAC;
   endfunction

   function automatic longint clip(input longint v, input longint hi, input longint lo);
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   task automatic filter_predict(input dsf_pkg::req_type r, output bit has_out,
                                 output dsf_pkg::rsp_type y);
      longint acc, gain, drive, nr, ni, u, total;
      int ch, en;
      ch = int'(r.channel);
      en = int'(r.entry_index);
      u = longint'(r.sample);
      has_out = 1'b0;
      y = '0;
      if (r.kind == dsf_pkg::KIND_CLEAR) begin
         foreach (hist_re[i, j]) begin
            hist_re[i][j] = 0;
            hist_im[i][j] = 0;
         end
      end else if (r.kind == dsf_pkg::KIND_WRITE && ch < NCH) begin
         if (r.coef_select == dsf_pkg::SEL_DIRECT) begin
            direct_tab[ch] = int'(r.coef_value);
         end else if (en < NST) begin
            case (r.coef_select)
               dsf_pkg::SEL_POLE_RE: pole_re_tab[ch][en] = int'(r.coef_value);
               dsf_pkg::SEL_POLE_IM: pole_im_tab[ch][en] = int'(r.coef_value);
               dsf_pkg::SEL_INPUT_GAIN: in_gain_tab[ch][en] = int'(r.coef_value);
               dsf_pkg::SEL_READ_RE: read_re_tab[ch][en] = int'(r.coef_value);
               dsf_pkg::SEL_READ_IM: read_im_tab[ch][en] = int'(r.coef_value);
               default: ;
            endcase
         end
      end else if (r.kind == dsf_pkg::KIND_SAMPLE && ch < NCH) begin
         acc = 0;
         for (int n = 0; n < NST; n++) begin
            gain = round_q20(longint'(step_now) * longint'(in_gain_tab[ch][n]));
            drive = round_q20(gain * u);
            nr = clip(round_q20(longint'(pole_re_tab[ch][n]) * hist_re[ch][n]
                  - longint'(pole_im_tab[ch][n]) * hist_im[ch][n]) + drive,
                  dsf_pkg::S32_MAX, dsf_pkg::S32_MIN);
            ni = clip(round_q20(longint'(pole_re_tab[ch][n]) * hist_im[ch][n]
                  + longint'(pole_im_tab[ch][n]) * hist_re[ch][n]),
                  dsf_pkg::S32_MAX, dsf_pkg::S32_MIN);
            hist_re[ch][n] = int'(nr);
            hist_im[ch][n] = int'(ni);
            acc += round_q20(longint'(read_re_tab[ch][n]) * nr
                  - longint'(read_im_tab[ch][n]) * ni);
         end
         total = 2 * acc + round_q20(longint'(direct_tab[ch]) * u);
         has_out = 1'b1;
         y.out_channel = r.channel;
         y.out_sample = 24'(clip(total, dsf_pkg::S24_MAX, dsf_pkg::S24_MIN));
         y.saturated = (total > dsf_pkg::S24_MAX) || (total < dsf_pkg::S24_MIN);
      end
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (quiet || p < 70) begin
         return 0;
      end else if (p < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 80);
   endfunction

   function automatic logic signed [23:0] pick_value();
      if ($urandom_range(0, 1) == 0) begin
         return 24'($signed($urandom_range(0, 1048575)) - 524288);
      end
      return 24'($urandom);
   endfunction

   // Samples only go to channels whose tables were loaded.
   function automatic dsf_pkg::req_type make_request();
      dsf_pkg::req_type r;
      int p;
      r = dsf_pkg::req_type'(63'({$urandom, $urandom}));
      p = $urandom_range(0, 99);
      if (p < 55) begin
         r.kind = dsf_pkg::KIND_SAMPLE;
         r.channel = 4'($urandom_range(0, NLOAD - 1));
      end else if (p < 85) begin
         r.kind = dsf_pkg::KIND_WRITE;
         r.coef_value = pick_value();
      end else if (p < 88) begin
         r.kind = dsf_pkg::KIND_CLEAR;
      end else begin
         r.kind = KIND_NONE;
      end
      return r;
   endfunction

   task automatic send_request(input dsf_pkg::req_type r, input bit known,
                               input dsf_pkg::rsp_type typed);
      bit has_out;
      dsf_pkg::rsp_type y;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      filter_predict(r, has_out, y);
      if (has_out) begin
         pending_outputs = {pending_outputs, (known ? typed : y)};
      end
      requests_sent++;
      if (r.kind == dsf_pkg::KIND_CLEAR) begin
         clears_sent++;
      end
   endtask

   task automatic write_step(input logic [22:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      step_now = value;
   endtask

   function automatic dsf_pkg::req_type coef_write(input int ch, input int en,
                                                   input logic [2:0] sel, input int value);
      dsf_pkg::req_type r;
      r = '0;
      r.kind = dsf_pkg::KIND_WRITE;
      r.channel = 4'(ch);
      r.entry_index = 6'(en);
      r.coef_select = sel;
      r.coef_value = 24'(value);
      return r;
   endfunction

   function automatic dsf_pkg::req_type sample_req(input int ch, input int value);
      dsf_pkg::req_type r;
      r = '0;
      r.kind = dsf_pkg::KIND_SAMPLE;
      r.channel = 4'(ch);
      r.sample = 24'(value);
      return r;
   endfunction

   function automatic vector_row_type row(input dsf_pkg::req_type r, input bit known = 1'b0,
                                          input int value = 0, input bit clipped = 1'b0);
      vector_row_type v;
      v.req = r;
      v.known = known;
      v.rsp.out_channel = r.channel;
      v.rsp.out_sample = 24'(value);
      v.rsp.saturated = clipped;
      return v;
   endfunction

   initial begin
      vector_row_type rows[$];
      dsf_pkg::req_type r;
      logic [22:0] steps[4];
      dsf_pkg::rsp_type none;
      none = '0;
      steps[0] = 23'd0;
      steps[1] = 23'h7FFFFF;
      steps[2] = 23'($urandom);
      steps[3] = dsf_pkg::STEP_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Channel 0 is all zero and channel 1 has a zero readout.
      quiet = 1'b1;
      for (int ch = 0; ch < NLOAD; ch++) begin
         for (int n = 0; n < NST; n++) begin
            for (int s = 0; s < 5; s++) begin
               send_request(coef_write(ch, n, 3'(s),
                            (ch == 0 || (ch == 1 && s >= 3)) ? 0 : pick_value()), 0, none);
            end
         end
         send_request(coef_write(ch, 0, dsf_pkg::SEL_DIRECT, ch == 0 ? 0 : pick_value()),
                      0, none);
      end
      quiet = 1'b0;

      rows = {rows, row(sample_req(0, 8388607), 1, 0, 0)};
      rows = {rows, row(coef_write(1, 0, dsf_pkg::SEL_DIRECT, 8388607))};
      rows = {rows, row(sample_req(1, 8388607), 1, 8388607, 1)};
      rows = {rows, row(sample_req(1, -8388608), 1, -8388608, 1)};
      rows = {rows, row(sample_req(1, 0), 1, 0, 0)};
      r = coef_write(2, 0, SEL_SPARE_A, 1);
      rows = {rows, row(r)};
      r.coef_select = SEL_SPARE_B;
      rows = {rows, row(r)};
      r.kind = KIND_NONE;
      rows = {rows, row(r)};
      rows = {rows, row(coef_write(2, 0, dsf_pkg::SEL_POLE_RE, 8388607))};
      rows = {rows, row(coef_write(2, 0, dsf_pkg::SEL_POLE_IM, -8388608))};
      rows = {rows, row(coef_write(2, 0, dsf_pkg::SEL_INPUT_GAIN, 8388607))};
      rows = {rows, row(coef_write(2, 0, dsf_pkg::SEL_READ_RE, 8388607))};
      rows = {rows, row(coef_write(2, 0, dsf_pkg::SEL_READ_IM, -8388608))};
      rows = {rows, row(coef_write(2, 0, dsf_pkg::SEL_DIRECT, -8388608))};
      rows = {rows, row(sample_req(2, 8388607))};
      rows = {rows, row(sample_req(2, -8388608))};
      rows = {rows, row(sample_req(2, 0))};
      rows = {rows, row(coef_write(15, 63, dsf_pkg::SEL_INPUT_GAIN, -8388608))};
      rows = {rows, row(coef_write(2, 63, dsf_pkg::SEL_INPUT_GAIN, -8388608))};
      rows = {rows, row(sample_req(2, -8388608))};
      r = '0;
      r.kind = dsf_pkg::KIND_CLEAR;
      rows = {rows, row(r)};
      rows = {rows, row(sample_req(2, 12345))};

      foreach (rows[i]) begin
         send_request(rows[i].req, rows[i].known, rows[i].rsp);
      end

      for (int phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            write_step(steps[phase - 1]);
         end
         quiet = (phase == 2);
         for (int i = 0; i < 100; i++) begin
            send_request(make_request(), 0, none);
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      done = 1'b1;
      $display("Sent %0d requests (%0d clears) over five step sizes; checked %0d outputs.",
               requests_sent, clears_sent, outputs_seen);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches or stray outputs.", errors);
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      dsf_pkg::rsp_type want;
      int burst;
      burst = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            outputs_seen++;
            if (pending_outputs.size() == 0) begin
               errors++;
               if (mismatches++ < 10) begin
                  $display("Unexpected output: ch %0d y %0d sat %0d",
                           rsp_data.out_channel, rsp_data.out_sample, rsp_data.saturated);
               end
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_data !== want) begin
                  errors++;
                  if (mismatches++ < 10) begin
                     $display("Mismatch: expected ch %0d y %0d sat %0d, got ch %0d y %0d sat %0d",
                              want.out_channel, want.out_sample, want.saturated,
                              rsp_data.out_channel, rsp_data.out_sample, rsp_data.saturated);
                  end
               end
            end
            if (outputs_seen == 100 && !hold_done) begin
               hold_cycles = 400;
               hold_done = 1'b1;
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 99) < 20) begin
            burst = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || done) begin
            idle_cycles = 0;
         end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without progress.", idle_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
hdl/dsf_pkg.sv
hdl/dsf_coef_mem.sv
hdl/dsf_state_mem.sv
hdl/dsf_datapath.sv
hdl/diagonal_state_space_filter.sv
tb/sv/tb_diagonal_state_space_filter.sv
